FILE: rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SMPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smpq assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smpq assertion failed");

`endif

FILE: rtl/smpq_pkg.sv
// shared types and constants for the sorted min priority queue
// no dependencies
`timescale 1ns / 1ps

package smpq_pkg;

	// default number of stored entries
	localparam int DEFAULT_DEPTH = 8;

	// payload widths
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 4;
	localparam int OUT_DATA_W = 40;

	// operation carried by an input item
	typedef enum logic [0:0] {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

FILE: rtl/sorted_min_priority_queue.sv
// Sorted min priority queue, top level.
// Input channel s_*: one item per operation; s_tuser is the kind (enqueue 0,
// dequeue 1), s_tdata the signed 32-bit value used on enqueue.
// Output channel m_*: exactly one result item per input item, in order.
// m_tuser is the status (done, rejected full, dequeue on empty), m_tdata
// holds the removed value (zero unless a dequeue succeeded) and the entry
// count after the operation, taken modulo 16.
// Entries sit in a row of sorted cells; every cell compares against the new
// value in parallel, so an insert or a removal is one update of the row.
// An accepted item is captured into an input register, then executed, and
// its result written to the output register, by the two-state controller
// (capture, then execute), one item at a time; s_tready is high only in the capture state.
// A result waits in the output register while m_tready is low; the next item
// can still be accepted, and its execution holds until the result is taken.
// Reset (arst_n low) empties the queue and drops any pending result; cell
// contents are not cleared and are never read before being written.
// Equal values leave in arrival order.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_min_priority_queue #(
	parameter int QUEUE_DEPTH = smpq_pkg::DEFAULT_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [smpq_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value
	input  logic                              s_tuser,   // [0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [smpq_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] removed_value, [35:32] entry_count
	output logic [1:0]                        m_tuser    // [1:0] status
);
	import smpq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t               cmd;
	dp_stat_t           stat;
	logic [1:0]         out_status;
	logic [VALUE_W-1:0] out_removed;
	logic [COUNT_W-1:0] out_count;
	logic [CW-1:0]      count;

	// controller
	smpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	smpq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CW          (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_kind     (s_tuser),
		.in_value    (s_tdata),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_status  (out_status),
		.out_removed (out_removed),
		.out_count   (out_count),
		.count       (count)
	);

	// output packing
	assign m_tdata = {{(OUT_DATA_W - VALUE_W - COUNT_W){1'b0}}, out_count, out_removed};
	assign m_tuser = out_status;

	// checks
	`SMPQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count <= CW'(QUEUE_DEPTH))
	`SMPQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`SMPQ_ASSERT_NOW(a_full_status, clk, arst_n, m_tvalid && (m_tuser == ST_FULL),
		count == CW'(QUEUE_DEPTH))
	`SMPQ_ASSERT_NOW(a_empty_status, clk, arst_n, m_tvalid && (m_tuser == ST_EMPTY),
		(count == '0) && (out_removed == '0))

endmodule

FILE: rtl/smpq_ctrl.sv
// controller state machine for the sorted min priority queue
// depends on smpq_pkg
`timescale 1ns / 1ps

module smpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  smpq_pkg::dp_stat_t  stat,
	output smpq_pkg::cmd_t      cmd
);
	import smpq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	// output register can take a new result this cycle
	assign out_free = !stat.out_busy || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_EXEC: begin
				cmd.exec = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/smpq_dp.sv
// datapath for the sorted min priority queue: sorted cells, count, result register
// depends on smpq_pkg
`timescale 1ns / 1ps

module smpq_dp #(
	parameter int QUEUE_DEPTH = smpq_pkg::DEFAULT_DEPTH,
	parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smpq_pkg::cmd_t                  cmd,
	output smpq_pkg::dp_stat_t              stat,
	input  logic                            in_kind,
	input  logic [smpq_pkg::VALUE_W-1:0]    in_value,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [1:0]                      out_status,
	output logic [smpq_pkg::VALUE_W-1:0]    out_removed,
	output logic [smpq_pkg::COUNT_W-1:0]    out_count,
	output logic [CW-1:0]                   count
);
	import smpq_pkg::*;

	logic [VALUE_W-1:0] cells_q [QUEUE_DEPTH];
	logic [VALUE_W-1:0] ins_d   [QUEUE_DEPTH];
	logic [VALUE_W-1:0] shf_d   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] lt;
	logic [QUEUE_DEPTH-1:0] ins_here;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          kind_q;
	logic [VALUE_W-1:0] value_q;
	logic          full;
	logic          empty;
	logic          do_enq;
	logic          do_deq;
	status_t       status_d;
	logic [CW+COUNT_W-1:0] count_ext;
	logic          out_valid_q;
	status_t       out_status_q;
	logic [VALUE_W-1:0] out_removed_q;
	logic [COUNT_W-1:0] out_count_q;

	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_enq = (kind_q == KIND_ENQ) && !full;
	assign do_deq = (kind_q == KIND_DEQ) && !empty;

	// per cell compare and next values for insert and remove
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		assign lt[g] = (CW'(g) < count_q) && ($signed(value_q) < $signed(cells_q[g]));
		assign ins_here[g] = lt[g] || (CW'(g) == count_q);
		if (g == 0) begin : g_first
			assign ins_d[g] = ins_here[g] ? value_q : cells_q[g];
		end else begin : g_rest
			assign ins_d[g] = !ins_here[g] ? cells_q[g] :
				(lt[g-1] ? cells_q[g-1] : value_q);
		end
		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign shf_d[g] = cells_q[g];
		end else begin : g_mid
			assign shf_d[g] = cells_q[g+1];
		end
	end

	// count and status after the operation
	always_comb begin
		count_d  = count_q;
		status_d = ST_DONE;
		if (kind_q == KIND_ENQ) begin
			if (full) status_d = ST_FULL;
			else      count_d  = count_q + CW'(1);
		end else begin
			if (empty) status_d = ST_EMPTY;
			else       count_d  = count_q - CW'(1);
		end
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_d};

	// captured input item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= in_kind;
			value_q <= in_value;
		end
	end

	// sorted cells, no reset: only cells below the count are read
	always_ff @(posedge clk) begin
		if (cmd.exec && do_enq) begin
			cells_q <= ins_d;
		end else if (cmd.exec && do_deq) begin
			cells_q <= shf_d;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status_q  <= status_d;
			out_removed_q <= do_deq ? cells_q[0] : '0;
			out_count_q   <= count_ext[COUNT_W-1:0];
		end
	end

	assign stat.out_busy = out_valid_q;
	assign out_valid     = out_valid_q;
	assign out_status    = out_status_q;
	assign out_removed   = out_removed_q;
	assign out_count     = out_count_q;
	assign count         = count_q;

endmodule
